/* hw/rtl/mskc_pkg.sv */
// Shared constants for the Mahalanobis skin pixel classifier.
// Holds reset values, register indexes and the term layout of the quadratic form.
// No dependencies.
package mskc_pkg;

    localparam int PIXEL_BITS_DEF = 8;
    localparam int COEF_W         = 32;
    localparam int MEAN_W         = 48;
    localparam int THR_W          = 16;
    localparam int DIST_W         = 40;
    localparam int NUM_COEF       = 6;
    localparam int APB_DATA_W     = 64;
    localparam int APB_ADDR_W     = 6;
    localparam int SPLIT_W        = 24;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_MEAN      = 3'd1;
    localparam logic [2:0] REG_COEF_BB   = 3'd2;
    localparam logic [2:0] REG_COEF_BG   = 3'd3;
    localparam logic [2:0] REG_COEF_BR   = 3'd4;
    localparam logic [2:0] REG_COEF_GG   = 3'd5;
    localparam logic [2:0] REG_COEF_GR   = 3'd6;
    localparam logic [2:0] REG_COEF_RR   = 3'd7;

    localparam logic [THR_W-1:0]    RESET_THRESHOLD = 16'd768;
    localparam logic [2*THR_W-1:0]  RESET_THR_SQ    = 32'd589824;
    localparam logic [MEAN_W-1:0]   RESET_MEAN      = 48'hCBFE_929A_71DF;
    localparam logic [COEF_W-1:0]   RESET_COEF_BB   = 32'sd87325;
    localparam logic [COEF_W-1:0]   RESET_COEF_BG   = -32'sd156672;
    localparam logic [COEF_W-1:0]   RESET_COEF_BR   = 32'sd62304;
    localparam logic [COEF_W-1:0]   RESET_COEF_GG   = 32'sd445474;
    localparam logic [COEF_W-1:0]   RESET_COEF_GR   = -32'sd261734;
    localparam logic [COEF_W-1:0]   RESET_COEF_RR   = 32'sd193046;

    // Term k of the form is dbl * c_k * d[row] * d[col], two bits per index.
    localparam logic [2*NUM_COEF-1:0] TERM_ROW = {2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};
    localparam logic [2*NUM_COEF-1:0] TERM_COL = {2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0};
    localparam logic [NUM_COEF-1:0]   TERM_DBL = 6'b010110;

endpackage

/* hw/rtl/mahalanobis_skin_pixel_classifier_top.sv */
// Top level of the Mahalanobis skin pixel classifier: APB register file and
// the seven-stage arithmetic pipeline. Depends on mskc_pkg.
//
// The block takes one pixel word per clock while the output side is not
// stalled, and returns one result word per pixel.
// Every multiplication is split into partial products of at most 32 by 32
// bits with a register after each, so the pipeline sustains one pixel per
// cycle; back-pressure on m_tready fills the stages before s_tready drops.
// The result carries the squared distance with 16 fraction bits in m_tdata
// and the skin flag in m_tuser. The user must write registers only while no
// pixel is in flight; the block itself does not enforce this.
module mahalanobis_skin_pixel_classifier_top #(
    parameter int PIXEL_BITS = mskc_pkg::PIXEL_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // blue, green, red from the lowest bit up, PIXEL_BITS each
    input  logic [((3*PIXEL_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // distance_squared (40 bits)
    output logic [mskc_pkg::DIST_W-1:0]          m_tdata,
    // is_skin
    output logic                                 m_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mskc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mskc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mskc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    localparam int NST  = 7;
    localparam int NC   = mskc_pkg::NUM_COEF;
    localparam int PW   = PIXEL_BITS + 8;
    localparam int DW   = PW + 1;
    localparam int MW   = mskc_pkg::COEF_W + DW;
    localparam int SW   = mskc_pkg::SPLIT_W;
    localparam int HIW  = MW - SW;
    localparam int LPW  = SW + 1 + DW;
    localparam int HPW  = HIW + DW;
    localparam int AW   = 2 * DW + 34;
    localparam int FRAC = 24;

    logic [mskc_pkg::THR_W-1:0]    thr_reg;
    logic [2*mskc_pkg::THR_W-1:0]  thr_sq_reg;
    logic [mskc_pkg::MEAN_W-1:0]   mean_reg;
    logic [mskc_pkg::COEF_W-1:0]   coef_reg [NC];
    logic                          wr_en;
    logic [2:0]                    wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= mskc_pkg::RESET_THRESHOLD;
            mean_reg    <= mskc_pkg::RESET_MEAN;
            coef_reg[0] <= mskc_pkg::RESET_COEF_BB;
            coef_reg[1] <= mskc_pkg::RESET_COEF_BG;
            coef_reg[2] <= mskc_pkg::RESET_COEF_BR;
            coef_reg[3] <= mskc_pkg::RESET_COEF_GG;
            coef_reg[4] <= mskc_pkg::RESET_COEF_GR;
            coef_reg[5] <= mskc_pkg::RESET_COEF_RR;
        end else if (wr_en) begin
            case (wr_idx)
                mskc_pkg::REG_THRESHOLD: thr_reg     <= pwdata[mskc_pkg::THR_W-1:0];
                mskc_pkg::REG_MEAN:      mean_reg    <= pwdata[mskc_pkg::MEAN_W-1:0];
                mskc_pkg::REG_COEF_BB:   coef_reg[0] <= pwdata[mskc_pkg::COEF_W-1:0];
                mskc_pkg::REG_COEF_BG:   coef_reg[1] <= pwdata[mskc_pkg::COEF_W-1:0];
                mskc_pkg::REG_COEF_BR:   coef_reg[2] <= pwdata[mskc_pkg::COEF_W-1:0];
                mskc_pkg::REG_COEF_GG:   coef_reg[3] <= pwdata[mskc_pkg::COEF_W-1:0];
                mskc_pkg::REG_COEF_GR:   coef_reg[4] <= pwdata[mskc_pkg::COEF_W-1:0];
                mskc_pkg::REG_COEF_RR:   coef_reg[5] <= pwdata[mskc_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            mskc_pkg::REG_THRESHOLD: prdata = 64'(thr_reg);
            mskc_pkg::REG_MEAN:      prdata = 64'(mean_reg);
            mskc_pkg::REG_COEF_BB:   prdata = 64'(coef_reg[0]);
            mskc_pkg::REG_COEF_BG:   prdata = 64'(coef_reg[1]);
            mskc_pkg::REG_COEF_BR:   prdata = 64'(coef_reg[2]);
            mskc_pkg::REG_COEF_GG:   prdata = 64'(coef_reg[3]);
            mskc_pkg::REG_COEF_GR:   prdata = 64'(coef_reg[4]);
            mskc_pkg::REG_COEF_RR:   prdata = 64'(coef_reg[5]);
            default:                 prdata = '0;
        endcase
    end

    // The squared threshold follows the register in the next cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_sq_reg <= mskc_pkg::RESET_THR_SQ;
        end else begin
            thr_sq_reg <= thr_reg * thr_reg;
        end
    end

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !v_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_tready = en[0];

    logic signed [DW-1:0]     d1_next  [3];
    logic signed [DW-1:0]     d1_reg   [3];
    logic signed [DW-1:0]     d2_reg   [3];
    logic signed [MW-1:0]     pc_reg   [NC];
    logic signed [LPW-1:0]    lo_reg   [NC];
    logic signed [HPW-1:0]    hi_reg   [NC];
    logic signed [AW-1:0]     term_reg [NC];
    logic signed [AW-1:0]     pair_reg [3];
    logic signed [AW-1:0]     sum_reg;
    logic [mskc_pkg::DIST_W-1:0] dist_next;
    logic [mskc_pkg::DIST_W-1:0] dist_reg;
    logic                     skin_reg;

    // Stage 1: signed difference of each channel from the mean, in Q8.8.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d1_next[k] = $signed({1'b0, s_tdata[k*PIXEL_BITS +: PIXEL_BITS], 8'd0})
                       - $signed({{(DW-16){1'b0}}, mean_reg[16*k +: 16]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            d1_reg <= d1_next;
        end
    end

    // Stage 2: coefficient times the column difference.
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            d2_reg <= d1_reg;
            for (int k = 0; k < NC; k++) begin
                pc_reg[k] <= $signed(coef_reg[k])
                           * d1_reg[mskc_pkg::TERM_COL[2*k +: 2]];
            end
        end
    end

    // Stage 3: split products, each half times the row difference.
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int k = 0; k < NC; k++) begin
                lo_reg[k] <= $signed({1'b0, pc_reg[k][SW-1:0]})
                           * d2_reg[mskc_pkg::TERM_ROW[2*k +: 2]];
                hi_reg[k] <= $signed(pc_reg[k][MW-1:SW])
                           * d2_reg[mskc_pkg::TERM_ROW[2*k +: 2]];
            end
        end
    end

    // Stage 4: recombine halves; off-diagonal terms count twice.
    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int k = 0; k < NC; k++) begin
                if (mskc_pkg::TERM_DBL[k]) begin
                    term_reg[k] <= ((AW'(hi_reg[k]) <<< SW) + AW'(lo_reg[k])) <<< 1;
                end else begin
                    term_reg[k] <= (AW'(hi_reg[k]) <<< SW) + AW'(lo_reg[k]);
                end
            end
        end
    end

    // Stages 5 and 6: adder tree.
    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int k = 0; k < 3; k++) begin
                pair_reg[k] <= term_reg[2*k] + term_reg[2*k+1];
            end
        end
        if (en[5]) begin
            sum_reg <= pair_reg[0] + pair_reg[1] + pair_reg[2];
        end
    end

    // Stage 7: floor to 16 fraction bits, clamp, saturate, compare.
    always_comb begin
        if (sum_reg[AW-1]) begin
            dist_next = '0;
        end else if (|sum_reg[AW-2:FRAC+mskc_pkg::DIST_W]) begin
            dist_next = '1;
        end else begin
            dist_next = sum_reg[FRAC+mskc_pkg::DIST_W-1:FRAC];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            dist_reg <= dist_next;
            skin_reg <= dist_next <= mskc_pkg::DIST_W'(thr_sq_reg);
        end
    end

    assign m_tvalid = v_reg[NST-1];
    assign m_tdata  = dist_reg;
    assign m_tuser  = skin_reg;

    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[NST-1] |-> s_tready)
        else $error("input stalled while output stage is empty");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[2] && !en[3]) |=> v_reg[2])
        else $error("word lost in a stalled pipeline stage");

    a_negative_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[5] && en[6] && sum_reg[AW-1]) |=> (dist_reg == '0 && skin_reg))
        else $error("negative form not clamped to zero");

    a_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[5] && en[6] && !sum_reg[AW-1] && |sum_reg[AW-2:FRAC+mskc_pkg::DIST_W])
        |=> (dist_reg == '1))
        else $error("overflowing distance not saturated");

endmodule

/* test/tb.sv */
// Self-checking testbench for mahalanobis_skin_pixel_classifier_top.
// Streams pixels under several register settings and checks each result word
// against a predictor that computes the quadratic form exactly; uses mskc_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mskc_pkg::*;

    localparam int PIX_W = 8;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic              is_skin;
        logic [DIST_W-1:0] dist_sq;
    } skin_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DIST_W-1:0] m_tdata;
    logic m_tuser;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    mahalanobis_skin_pixel_classifier_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 aclk = ~aclk;

    // Mirror of the register file as the predictor sees it.
    logic [THR_W-1:0]  thr_reg  = RESET_THRESHOLD;
    logic [MEAN_W-1:0] mean_reg = RESET_MEAN;
    logic [COEF_W-1:0] coef_reg [NUM_COEF] = '{RESET_COEF_BB, RESET_COEF_BG, RESET_COEF_BR,
                                              RESET_COEF_GG, RESET_COEF_GR, RESET_COEF_RR};

    pixel_t       pending_pixels [$];
    skin_result_t expected_results [$];
    pixel_t       next_px;
    skin_result_t want;
    bit idling_on = 1'b1;
    bit pix_taken = 1'b0;
    int s_gap = 0;
    int m_gap = 0;
    int outstanding = 0;
    int n_errors = 0;
    int n_results = 0;
    int n_zero = 0;
    int n_sat = 0;
    int n_skin = 0;
    int n_configs = 0;

    function automatic skin_result_t classify(pixel_t px);
        logic [PIX_W-1:0] ch [3];
        logic signed [127:0] d [3];
        logic signed [127:0] c [NUM_COEF];
        logic signed [127:0] sum;
        logic signed [127:0] q;
        logic [31:0] thr_sq;
        skin_result_t r;
        ch[0] = px.blue;
        ch[1] = px.green;
        ch[2] = px.red;
        for (int k = 0; k < 3; k++) begin
            d[k] = {112'd0, ch[k], 8'd0} - {112'd0, mean_reg[16*k +: 16]};
        end
        for (int k = 0; k < NUM_COEF; k++) begin
            c[k] = {{96{coef_reg[k][31]}}, coef_reg[k]};
        end
        // The exact sum carries 40 fraction bits; the shift floors it to 16.
        sum = d[0]*d[0]*c[0] + 2*d[0]*d[1]*c[1] + 2*d[0]*d[2]*c[2]
            + d[1]*d[1]*c[3] + 2*d[1]*d[2]*c[4] + d[2]*d[2]*c[5];
        q = sum >>> 24;
        if (sum < 0) begin
            r.dist_sq = '0;
        end else if (q[127:DIST_W] != 0) begin
            r.dist_sq = '1;
        end else begin
            r.dist_sq = q[DIST_W-1:0];
        end
        thr_sq = thr_reg * thr_reg;
        r.is_skin = (r.dist_sq <= {8'd0, thr_sq});
        return r;
    endfunction

    task automatic note_error(string what, logic [DIST_W-1:0] exp_v, logic [DIST_W-1:0] got_v);
        n_errors++;
        if (n_errors <= 10) begin
            $display("%0t ns: %s: expected %0h, got %0h", $time, what, exp_v, got_v);
        end
    endtask

    // Input acceptance, prediction and result checking, all at the rising edge.
    always @(posedge aclk) begin
        pix_taken = aresetn && s_tvalid && s_tready;
        if (pix_taken) begin
            expected_results.push_back(classify(pixel_t'({s_tdata[7:0], s_tdata[15:8],
                                                          s_tdata[23:16]})));
        end
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            outstanding--;
            if (expected_results.size() == 0) begin
                note_error("result word with no pixel pending", '0, m_tdata);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata !== want.dist_sq) note_error("distance_squared", want.dist_sq, m_tdata);
                if (m_tuser !== want.is_skin) note_error("is_skin", want.is_skin, m_tuser);
                if (want.dist_sq == 0) n_zero++;
                if (want.dist_sq == '1) n_sat++;
                if (want.is_skin) n_skin++;
            end
        end
    end

    // Pixel driver: holds a word until it is taken, with random gaps.
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || pix_taken)) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (idling_on && $urandom_range(4) == 0) begin
                s_gap = $urandom_range(0, 2);
                s_tvalid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                next_px = pending_pixels.pop_front();
                s_tdata <= {next_px.red, next_px.green, next_px.blue};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_gap--;
            m_tready <= 1'b0;
        end else if (idling_on && $urandom_range(4) == 0) begin
            m_gap = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_THRESHOLD: thr_reg = value[THR_W-1:0];
            REG_MEAN:      mean_reg = value[MEAN_W-1:0];
            default:       coef_reg[idx - REG_COEF_BB] = value[COEF_W-1:0];
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Coefficients are packed with blue-blue in the lowest 32 bits.
    task automatic load_config(input logic [THR_W-1:0] thr, input logic [MEAN_W-1:0] mean,
                               input logic [COEF_W*NUM_COEF-1:0] coefs);
        apb_write(REG_THRESHOLD, {48'd0, thr});
        apb_write(REG_MEAN, {16'd0, mean});
        for (int k = 0; k < NUM_COEF; k++) begin
            apb_write(REG_COEF_BB + 3'(k), {32'd0, coefs[COEF_W*k +: COEF_W]});
        end
        n_configs++;
    endtask

    task automatic queue_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        pending_pixels.push_back('{b, g, r});
        outstanding++;
    endtask

    // The sender stays paused here until every pixel has produced its result.
    task automatic wait_drained();
        do @(negedge aclk); while (outstanding > 0);
    endtask

    initial begin
        logic [THR_W-1:0] thr;
        logic [MEAN_W-1:0] mean;
        logic [COEF_W*NUM_COEF-1:0] coefs;
        logic [31:0] cw;
        logic [7:0] ch [3];
        int nb;
        int v;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset statistics: channel extremes, pixels just above and below the mean and bit patterns.
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0, 8'd0);
        queue_pixel(8'd0, 8'd255, 8'd0);
        queue_pixel(8'd0, 8'd0, 8'd255);
        queue_pixel(8'd114, 8'd147, 8'd204);
        queue_pixel(8'd113, 8'd146, 8'd203);
        queue_pixel(8'hAA, 8'h55, 8'hAA);
        queue_pixel(8'h55, 8'hAA, 8'h55);
        wait_drained();

        // A negative semidefinite form must clamp to zero and count as skin.
        load_config(16'd0, 48'd0, {{5{32'd0}}, 32'h8000_0000});
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd1, 8'd0, 8'd0);
        queue_pixel(8'd0, 8'd0, 8'd0);
        wait_drained();

        // Largest coefficients and mean so the sum saturates for pixels far from the mean.
        load_config(16'hFFFF, '1, {6{32'h7FFF_FFFF}});
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd128, 8'd0, 8'd255);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            idling_on = (ph != 2) && (ph != 5);
            thr = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
            if (ph == 0) begin
                mean = RESET_MEAN;
                coefs = {RESET_COEF_RR, RESET_COEF_GR, RESET_COEF_GG,
                         RESET_COEF_BR, RESET_COEF_BG, RESET_COEF_BB};
            end else begin
                mean = 48'({$urandom, $urandom});
                for (int k = 0; k < NUM_COEF; k++) begin
                    // Random magnitude: keep nb low bits, sign-extended.
                    cw = $urandom;
                    nb = $urandom_range(1, 32);
                    cw = cw << (32 - nb);
                    cw = $signed(cw) >>> (32 - nb);
                    coefs[COEF_W*k +: COEF_W] = cw;
                end
            end
            load_config(thr, mean, coefs);
            for (int n = 0; n < 65; n++) begin
                for (int k = 0; k < 3; k++) begin
                    if ($urandom_range(9) < 6) begin
                        v = int'(mean_reg[16*k+8 +: 8]) + int'($urandom_range(0, 16)) - 8;
                        if (v < 0) v = 0;
                        if (v > 255) v = 255;
                        ch[k] = v[7:0];
                    end else begin
                        ch[k] = 8'($urandom);
                    end
                end
                queue_pixel(ch[0], ch[1], ch[2]);
            end
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        n_errors += expected_results.size();
        $display("Checked %0d result words under %0d register settings plus reset values.",
                 n_results, n_configs);
        $display("Of these %0d were zero, %0d saturated and %0d classified as skin.",
                 n_zero, n_sat, n_skin);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* mahalanobis_skin_pixel_classifier_top.f */
hw/rtl/mskc_pkg.sv
hw/rtl/mahalanobis_skin_pixel_classifier_top.sv
test/tb.sv
